>>> src/h264_poc_pkg.sv
// Shared types and constants of the H.264 picture order count block.
// Used by h264_picture_order_count and h264_poc_div under src; it depends on nothing else.
package h264_poc_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 256;

    // Widths fixed by the slice header syntax.
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned FNUM_W     = 16;
    localparam int unsigned LSB_W      = 16;
    localparam int unsigned LOG2_W     = 5;
    localparam int unsigned TYPE_W     = 2;
    localparam int unsigned CYCLE_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;

    // Iterative divider: the dividend is a positive 32-bit count minus one.
    localparam int unsigned DIV_N_W    = 31;
    localparam int unsigned DIV_D_W    = CYCLE_W;
    localparam int unsigned DIV_CNT_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG2_FRAME_NUM = 3'd0,
        CFG_LOG2_ORDER_LSB = 3'd1,
        CFG_ORDER_TYPE     = 3'd2,
        CFG_FRAMES_ONLY    = 3'd3,
        CFG_CYCLE_LENGTH   = 3'd4,
        CFG_OFFSET_NONREF  = 3'd5,
        CFG_OFFSET_T2B     = 3'd6,
        CFG_TABLE_LOAD     = 3'd7
    } t_cfg_idx;

    typedef enum logic [TYPE_W-1:0] {
        POC_TYPE_LSB   = 2'd0,
        POC_TYPE_CYCLE = 2'd1,
        POC_TYPE_FRAME = 2'd2,
        POC_TYPE_NONE  = 2'd3
    } t_poc_type;

    typedef struct packed {
        logic                     is_idr;
        logic                     is_reference;
        logic                     field_picture;
        logic                     bottom_field;
        logic [FNUM_W-1:0]        frame_number;
        logic [FNUM_W-1:0]        prev_frame_number;
        logic [WORD_W-1:0]        prev_frame_offset;
        logic [LSB_W-1:0]         order_lsb;
        logic [LSB_W-1:0]         prev_order_lsb;
        logic signed [WORD_W-1:0] prev_order_msb;
        logic signed [WORD_W-1:0] delta_first;
        logic signed [WORD_W-1:0] delta_second;
    } t_poc_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] order_count;
        logic [WORD_W-1:0]        frame_offset;
        logic signed [WORD_W-1:0] order_msb;
    } t_poc_out;

endpackage

>>> src/h264_picture_order_count.sv
// Top level of the H.264 picture order count block: sequencer, shared adder,
// configuration registers. Depends on h264_poc_pkg, h264_poc_table, h264_poc_div.
//
// One slice header beat in gives one result beat out: the picture order count,
// the new frame number offset and the new POC MSB (zero outside type 0). The
// caller keeps the previous picture's values. A single 32-bit adder does every
// sum, one per cycle under the sequencer. From acceptance to the output register
// an item passes S_FOFF, S_FSUM and S_SEL; type 2 adds S_T2, type 0 adds S_MSB,
// S_T0TOP and S_T0BOT, type 1 adds S_ABSF, S_NONREF, S_T1TOP, S_T1BOT, S_T1DLT.
// For a positive absolute frame number type 1 also runs the 31-step divider,
// reads the table once per cycle over cycle_length entries, then S_MUL and S_EXP.
// The block takes a new beat in the cycle after the previous result enters the
// output register, which holds it until the receiver takes it.
// Writes to cycle_length rewind the table load pointer; each write to
// cycle_table_load stores the next table entry.
module h264_picture_order_count #(
    parameter int unsigned TABLE_DEPTH = h264_poc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  h264_poc_pkg::t_poc_in               i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output h264_poc_pkg::t_poc_out              o_data,
    input  logic                                i_cfg_we,
    input  logic [h264_poc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [h264_poc_pkg::WORD_W-1:0]     i_cfg_data
);
    import h264_poc_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_FOFF   = 17'h00002,
        S_FSUM   = 17'h00004,
        S_MSB    = 17'h00008,
        S_T0TOP  = 17'h00010,
        S_T0BOT  = 17'h00020,
        S_T2     = 17'h00040,
        S_ABSF   = 17'h00080,
        S_DIV    = 17'h00100,
        S_WALK   = 17'h00200,
        S_MUL    = 17'h00400,
        S_EXP    = 17'h00800,
        S_NONREF = 17'h01000,
        S_T1TOP  = 17'h02000,
        S_T1BOT  = 17'h04000,
        S_T1DLT  = 17'h08000,
        S_SEL    = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [LOG2_W-1:0]  r_log2_fn;
    logic [LOG2_W-1:0]  r_log2_lsb;
    t_poc_type          r_type;
    logic               r_frames_only;
    logic [CYCLE_W-1:0] r_cycle_len;
    logic [WORD_W-1:0]  r_off_nr;
    logic [WORD_W-1:0]  r_off_tb;
    logic [CYCLE_W-1:0] r_load_idx;
    logic [AW-1:0]      r_wr_addr;

    // Datapath registers.
    t_poc_in            r_in;
    logic [WORD_W-1:0]  r_foff;
    logic [WORD_W-1:0]  r_fsum;
    logic [WORD_W-1:0]  r_msb;
    logic [WORD_W-1:0]  r_top;
    logic [WORD_W-1:0]  r_bot;
    logic [WORD_W-1:0]  r_csum;
    logic [WORD_W-1:0]  r_pref;
    logic [WORD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_exp;
    logic [CYCLE_W-1:0] r_walk_idx;
    logic [AW-1:0]      r_rd_addr;
    logic               r_rd_vld;
    logic [CYCLE_W-1:0] r_rd_tag;
    t_poc_out           r_out;
    logic               r_out_vld;

    logic               accept;
    logic               field;
    logic               bottom;
    logic               top;
    logic               tbl_we;
    logic               issue;
    logic               out_load;
    logic [WORD_W-1:0]  max_fnum;
    logic [WORD_W-1:0]  max_lsb;
    logic [WORD_W-1:0]  half_lsb;
    logic [LSB_W-1:0]   lsb_prev;
    logic [WORD_W-1:0]  msb_prev;
    logic               wrap_up;
    logic               wrap_down;
    logic               abs_pos;
    logic [WORD_W-1:0]  add_a;
    logic [WORD_W-1:0]  add_b;
    logic [WORD_W-1:0]  add_y;
    logic [WORD_W-1:0]  mul_y;
    logic [WORD_W-1:0]  poc;
    logic [WORD_W-1:0]  rd_data;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_D_W-1:0] div_rem;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_SEL) && (!r_out_vld || !i_stall);

    assign field  = r_in.field_picture && !r_frames_only;
    assign bottom = field && r_in.bottom_field;
    assign top    = field && !r_in.bottom_field;

    assign max_fnum = WORD_W'(1) << r_log2_fn;
    assign max_lsb  = WORD_W'(1) << r_log2_lsb;
    assign half_lsb = max_lsb >> 1;
    assign lsb_prev = r_in.is_idr ? '0 : r_in.prev_order_lsb;
    assign msb_prev = r_in.is_idr ? '0 : r_in.prev_order_msb;

    assign wrap_up   = (r_in.order_lsb < lsb_prev)
                    && ({{(WORD_W-LSB_W){1'b0}}, lsb_prev - r_in.order_lsb} >= half_lsb);
    assign wrap_down = (r_in.order_lsb > lsb_prev)
                    && ({{(WORD_W-LSB_W){1'b0}}, r_in.order_lsb - lsb_prev} > half_lsb);

    // A non-reference picture steps the absolute frame number back by one,
    // so it must exceed one to leave a positive count.
    assign abs_pos = (r_cycle_len != '0)
                  && (r_in.is_reference ? ($signed(r_fsum) > 32'sd0)
                                        : ($signed(r_fsum) > 32'sd1));

    // Shared adder: operands picked by the sequencer state.
    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (r_state)
            S_FOFF: begin
                add_a = r_in.prev_frame_offset;
                add_b = (r_in.frame_number < r_in.prev_frame_number) ? max_fnum : '0;
            end
            S_FSUM: begin
                add_a = r_foff;
                add_b = {{(WORD_W-FNUM_W){1'b0}}, r_in.frame_number};
            end
            S_MSB: begin
                add_a = msb_prev;
                add_b = wrap_up ? max_lsb : (wrap_down ? (~max_lsb + 1'b1) : '0);
            end
            S_T0TOP: begin
                add_a = r_msb;
                add_b = {{(WORD_W-LSB_W){1'b0}}, r_in.order_lsb};
            end
            S_T0BOT: begin
                add_a = r_top;
                add_b = r_in.delta_second;
            end
            S_T2: begin
                add_a = {r_fsum[WORD_W-2:0], 1'b0};
                add_b = r_in.is_reference ? '0 : '1;
            end
            S_ABSF: begin
                add_a = r_fsum;
                add_b = r_in.is_reference ? '1 : ~WORD_W'(1);
            end
            S_WALK: begin
                add_a = r_csum;
                add_b = rd_data;
            end
            S_EXP: begin
                add_a = r_prod;
                add_b = r_pref;
            end
            S_NONREF: begin
                add_a = r_exp;
                add_b = r_in.is_reference ? '0 : r_off_nr;
            end
            S_T1TOP: begin
                add_a = r_exp;
                add_b = r_in.delta_first;
            end
            S_T1BOT: begin
                add_a = r_top;
                add_b = r_off_tb;
            end
            S_T1DLT: begin
                add_a = r_bot;
                add_b = field ? '0 : r_in.delta_second;
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_y = add_a + add_b;
    assign mul_y = {1'b0, div_quo} * r_csum;
    assign issue = (r_state == S_WALK) && (r_walk_idx != r_cycle_len);

    always_comb begin
        if (top) begin
            poc = r_top;
        end else if (bottom) begin
            poc = r_bot;
        end else begin
            poc = ($signed(r_top) < $signed(r_bot)) ? r_top : r_bot;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_FOFF;
            S_FOFF:   n_state = S_FSUM;
            S_FSUM: begin
                unique case (r_type)
                    POC_TYPE_LSB:   n_state = S_MSB;
                    POC_TYPE_CYCLE: n_state = S_ABSF;
                    POC_TYPE_FRAME: n_state = S_T2;
                    default:        n_state = S_SEL;
                endcase
            end
            S_MSB:    n_state = S_T0TOP;
            S_T0TOP:  n_state = S_T0BOT;
            S_T0BOT:  n_state = S_SEL;
            S_T2:     n_state = S_SEL;
            S_ABSF:   n_state = abs_pos ? S_DIV : S_NONREF;
            S_DIV:    if (div_done) n_state = S_WALK;
            S_WALK:   if (!issue && !r_rd_vld) n_state = S_MUL;
            S_MUL:    n_state = S_EXP;
            S_EXP:    n_state = S_NONREF;
            S_NONREF: n_state = S_T1TOP;
            S_T1TOP:  n_state = S_T1BOT;
            S_T1BOT:  n_state = S_T1DLT;
            S_T1DLT:  n_state = S_SEL;
            S_SEL:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded as the sequencer steps.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        unique case (r_state)
            S_FOFF:  r_foff <= r_in.is_idr ? '0 : add_y;
            S_FSUM: begin
                r_fsum <= add_y;
                r_top  <= '0;
                r_bot  <= '0;
            end
            S_MSB:   r_msb <= add_y;
            S_T0TOP: r_top <= add_y;
            S_T0BOT: r_bot <= field ? r_top : add_y;
            S_T2: begin
                r_top <= r_in.is_idr ? '0 : add_y;
                r_bot <= r_in.is_idr ? '0 : add_y;
            end
            S_ABSF: begin
                r_exp      <= '0;
                r_csum     <= '0;
                r_pref     <= '0;
                r_walk_idx <= '0;
                r_rd_addr  <= '0;
            end
            S_WALK: begin
                if (issue) begin
                    r_walk_idx <= r_walk_idx + 1'b1;
                    r_rd_addr  <= (r_rd_addr == AW'(TABLE_DEPTH - 1)) ? '0
                                                                      : r_rd_addr + 1'b1;
                    r_rd_tag   <= r_walk_idx;
                end
                // The running sum at the cycle position is the partial cycle.
                if (r_rd_vld) begin
                    r_csum <= add_y;
                    if (r_rd_tag == div_rem) begin
                        r_pref <= add_y;
                    end
                end
            end
            S_MUL:    r_prod <= mul_y;
            S_EXP:    r_exp  <= add_y;
            S_NONREF: r_exp  <= add_y;
            S_T1TOP:  r_top  <= add_y;
            S_T1BOT:  r_bot  <= add_y;
            S_T1DLT:  r_bot  <= add_y;
            default: ;
        endcase
        if (out_load) begin
            r_out.order_count  <= poc;
            r_out.frame_offset <= r_foff;
            r_out.order_msb    <= (r_type == POC_TYPE_LSB) ? r_msb : '0;
        end
    end

    // Configuration register writes.
    assign tbl_we = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_TABLE_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_fn     <= LOG2_W'(4);
            r_log2_lsb    <= LOG2_W'(4);
            r_type        <= POC_TYPE_LSB;
            r_frames_only <= 1'b0;
            r_cycle_len   <= '0;
            r_off_nr      <= '0;
            r_off_tb      <= '0;
            r_load_idx    <= '0;
            r_wr_addr     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOG2_FRAME_NUM: r_log2_fn     <= i_cfg_data[LOG2_W-1:0];
                CFG_LOG2_ORDER_LSB: r_log2_lsb    <= i_cfg_data[LOG2_W-1:0];
                CFG_ORDER_TYPE:     r_type        <= t_poc_type'(i_cfg_data[TYPE_W-1:0]);
                CFG_FRAMES_ONLY:    r_frames_only <= i_cfg_data[0];
                CFG_CYCLE_LENGTH: begin
                    r_cycle_len <= i_cfg_data[CYCLE_W-1:0];
                    r_load_idx  <= '0;
                    r_wr_addr   <= '0;
                end
                CFG_OFFSET_NONREF:  r_off_nr      <= i_cfg_data;
                CFG_OFFSET_T2B:     r_off_tb      <= i_cfg_data;
                CFG_TABLE_LOAD: begin
                    // The table address follows the 8-bit load pointer modulo the depth.
                    r_load_idx <= r_load_idx + 1'b1;
                    if (r_load_idx == '1 || r_wr_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_wr_addr <= '0;
                    end else begin
                        r_wr_addr <= r_wr_addr + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    h264_poc_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (i_cfg_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    h264_poc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     ((r_state == S_ABSF) && abs_pos),
        .i_dividend  (add_y[DIV_N_W-1:0]),
        .i_divisor   (r_cycle_len),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FOFF))
        else $error("accepted beat did not start the sequencer");

    a_div_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_read_in_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_WALK))
        else $error("table read data arrived outside the table walk");

    a_result_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (r_state == S_IDLE)))
        else $error("result was not presented after the final step");

endmodule

>>> src/h264_poc_table.sv
// Reference frame offset table: one write port, one registered read port.
// Depends on nothing but its parameters.
module h264_poc_table #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/h264_poc_div.sv
// Restoring divider, one quotient bit per cycle, for the offset cycle position.
// Depends on h264_poc_pkg for its widths.
module h264_poc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [h264_poc_pkg::DIV_N_W-1:0]  i_dividend,
    input  logic [h264_poc_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [h264_poc_pkg::DIV_N_W-1:0]  o_quotient,
    output logic [h264_poc_pkg::DIV_D_W-1:0]  o_remainder
);
    import h264_poc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign shifted = {r_rem, r_quo[DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
            r_rem <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> dv/tb_h264_picture_order_count.sv
// Self-checking testbench for h264_picture_order_count: a clocked driver and monitor
// around the block, with its own picture order count predictor and configuration copy.
// Depends on h264_poc_pkg and the block's RTL under src.
`timescale 1ns / 100ps

module tb_h264_picture_order_count;
    import h264_poc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RX_HOLD_CYCLES = 400;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_poc_in               i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_poc_out              o_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [WORD_W-1:0]     i_cfg_data = '0;

    // Copy of the configuration as the block should hold it.
    logic [LOG2_W-1:0]     cfg_log2_fnum;
    logic [LOG2_W-1:0]     cfg_log2_lsb;
    t_poc_type             cfg_type;
    logic                  cfg_frames_only;
    logic [CYCLE_W-1:0]    cfg_cycle_len;
    logic [WORD_W-1:0]     cfg_off_nonref;
    logic [WORD_W-1:0]     cfg_off_t2b;
    logic [WORD_W-1:0]     cycle_table [0:DEF_TABLE_DEPTH-1];
    logic [CYCLE_W-1:0]    table_ptr;

    t_poc_in               slice_queue [$];
    t_poc_out              poc_expected [$];
    t_poc_out              want;
    int                    slices_accepted = 0;
    int                    results_checked = 0;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    int                    rx_beats = 0;
    int                    rx_hold_left = 0;
    bit                    rx_hold_done = 1'b0;
    bit                    steady = 1'b0;

    h264_picture_order_count uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_poc_out predict_poc(t_poc_in s);
        logic              idr, ref_pic, fld, bot, top_f;
        logic [WORD_W-1:0] fnum, fnum_prev, foff, lsb, lsb_prev, msb_prev, d0, d1;
        logic [WORD_W-1:0] max_fnum, max_lsb, half, msb, top_poc, bot_poc, poc;
        logic [WORD_W-1:0] sum32, cycle_sum, expc, a, cnt, pos, len;
        longint            absf;
        t_poc_out          r;
        idr       = s.is_idr;
        ref_pic   = s.is_reference;
        fld       = s.field_picture && !cfg_frames_only;
        bot       = fld && s.bottom_field;
        top_f     = fld && !bot;
        fnum      = {16'd0, s.frame_number};
        fnum_prev = {16'd0, s.prev_frame_number};
        foff      = s.prev_frame_offset;
        lsb       = {16'd0, s.order_lsb};
        lsb_prev  = {16'd0, s.prev_order_lsb};
        msb_prev  = s.prev_order_msb;
        d0        = s.delta_first;
        d1        = s.delta_second;
        max_fnum  = 32'd1 << cfg_log2_fnum;
        len       = {24'd0, cfg_cycle_len};
        msb       = '0;
        top_poc   = '0;
        bot_poc   = '0;

        if (idr) begin
            lsb_prev = '0;
            msb_prev = '0;
            foff     = '0;
        end else if (fnum < fnum_prev) begin
            foff = foff + max_fnum;
        end

        case (cfg_type)
            POC_TYPE_LSB: begin
                max_lsb = 32'd1 << cfg_log2_lsb;
                half    = max_lsb >> 1;
                if (lsb < lsb_prev && lsb_prev - lsb >= half)
                    msb = msb_prev + max_lsb;
                else if (lsb > lsb_prev && lsb - lsb_prev > half)
                    msb = msb_prev - max_lsb;
                else
                    msb = msb_prev;
                top_poc = msb + lsb;
                bot_poc = fld ? msb + lsb : top_poc + d1;
            end
            POC_TYPE_CYCLE: begin
                absf      = 0;
                cycle_sum = '0;
                expc      = '0;
                if (len != 0) begin
                    sum32 = foff + fnum;
                    absf  = longint'($signed(sum32));
                end
                if (!ref_pic && absf > 0)
                    absf = absf - 1;
                for (int i = 0; i < len; i++)
                    cycle_sum = cycle_sum + cycle_table[i];
                if (absf > 0) begin
                    a    = 32'(absf - 1);
                    cnt  = a / len;
                    pos  = a % len;
                    expc = cnt * cycle_sum;
                    for (int i = 0; i <= pos; i++)
                        expc = expc + cycle_table[i];
                end
                if (!ref_pic)
                    expc = expc + cfg_off_nonref;
                top_poc = expc + d0;
                bot_poc = top_poc + cfg_off_t2b;
                if (!fld)
                    bot_poc = bot_poc + d1;
            end
            POC_TYPE_FRAME: begin
                if (!idr) begin
                    top_poc = 32'd2 * (foff + fnum);
                    if (!ref_pic)
                        top_poc = top_poc - 32'd1;
                end
                bot_poc = top_poc;
            end
            default: begin
            end
        endcase

        if (top_f)
            poc = top_poc;
        else if (bot)
            poc = bot_poc;
        else
            poc = ($signed(top_poc) < $signed(bot_poc)) ? top_poc : bot_poc;

        r.order_count  = poc;
        r.frame_offset = foff;
        r.order_msb    = msb;
        return r;
    endfunction

    // Mostly slices whose numbers sit inside the configured moduli, so the wrap
    // and cycle paths are reached; the rest is raw noise over every bit.
    function automatic t_poc_in gen_slice();
        t_poc_in           s;
        logic [15:0]       fmask, lmask;
        int                k;
        fmask = (cfg_log2_fnum >= 16) ? 16'hFFFF : 16'((32'd1 << cfg_log2_fnum) - 1);
        lmask = (cfg_log2_lsb >= 16) ? 16'hFFFF : 16'((32'd1 << cfg_log2_lsb) - 1);
        s.is_idr        = ($urandom_range(9) == 0);
        s.is_reference  = ($urandom_range(3) != 0);
        s.field_picture = 1'($urandom_range(1));
        s.bottom_field  = 1'($urandom_range(1));
        if ($urandom_range(9) < 7) begin
            s.frame_number      = 16'($urandom) & fmask;
            s.prev_frame_number = $urandom_range(1) ? ((s.frame_number - 16'd1) & fmask)
                                                    : (16'($urandom) & fmask);
            s.prev_frame_offset = $urandom_range(0, 50000);
            s.order_lsb         = 16'($urandom) & lmask;
            s.prev_order_lsb    = 16'($urandom) & lmask;
            k = $urandom_range(0, 64);
            s.prev_order_msb    = (k - 32) * (32'd1 << cfg_log2_lsb);
            k = $urandom_range(0, 64);
            s.delta_first       = k - 32;
            k = $urandom_range(0, 64);
            s.delta_second      = k - 32;
        end else begin
            s.frame_number      = 16'($urandom);
            s.prev_frame_number = 16'($urandom);
            s.prev_frame_offset = $urandom;
            s.order_lsb         = 16'($urandom);
            s.prev_order_lsb    = 16'($urandom);
            s.prev_order_msb    = $urandom;
            s.delta_first       = $urandom;
            s.delta_second      = $urandom;
        end
        return s;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [WORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LOG2_FRAME_NUM: cfg_log2_fnum   = value[LOG2_W-1:0];
            CFG_LOG2_ORDER_LSB: cfg_log2_lsb    = value[LOG2_W-1:0];
            CFG_ORDER_TYPE:     cfg_type        = t_poc_type'(value[TYPE_W-1:0]);
            CFG_FRAMES_ONLY:    cfg_frames_only = value[0];
            CFG_CYCLE_LENGTH: begin
                cfg_cycle_len = value[CYCLE_W-1:0];
                table_ptr     = '0;
            end
            CFG_OFFSET_NONREF:  cfg_off_nonref  = value;
            CFG_OFFSET_T2B:     cfg_off_t2b     = value;
            CFG_TABLE_LOAD: begin
                cycle_table[table_ptr] = value;
                table_ptr              = table_ptr + 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    task automatic cfg_release();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(int log2_fnum, int log2_lsb, t_poc_type kind, bit frames);
        cfg_write(CFG_LOG2_FRAME_NUM, log2_fnum);
        cfg_write(CFG_LOG2_ORDER_LSB, log2_lsb);
        cfg_write(CFG_ORDER_TYPE, 32'(kind));
        cfg_write(CFG_FRAMES_ONLY, 32'(frames));
        cfg_release();
    endtask

    // Writes both offsets, rewinds the load pointer and writes n entries; n above 256 wraps it.
    task automatic load_cycle(int len, int n, logic [WORD_W-1:0] nonref,
                              logic [WORD_W-1:0] t2b);
        logic [WORD_W-1:0] v;
        cfg_write(CFG_OFFSET_NONREF, nonref);
        cfg_write(CFG_OFFSET_T2B, t2b);
        cfg_write(CFG_CYCLE_LENGTH, len);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0001;
                2:       v = $urandom;
                default: v = $urandom_range(0, 60) - 20;
            endcase
            cfg_write(CFG_TABLE_LOAD, v);
        end
        cfg_release();
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            slice_queue.push_back(gen_slice());
    endtask

    // Waits until the sender has no slice left and every expected result is back,
    // then lets the block idle before any register changes.
    task automatic drain();
        do @(negedge i_clk);
        while (slice_queue.size() != 0 || i_valid || poc_expected.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    // Sender: offers queued slices, holds a stalled beat unchanged.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                poc_expected.push_back(predict_poc(i_data));
                slices_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (slice_queue.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
                    i_valid <= 1'b1;
                    i_data  <= slice_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls unless steady, plus one long hold-off once traffic is flowing.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            rx_beats++;
        if (!rx_hold_done && rx_beats >= 200) begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0)
            rx_hold_left--;
        i_stall <= (rx_hold_left != 0) || (!steady && $urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (poc_expected.size() == 0) begin
                $display("%0t: result beat with nothing expected: %h", $time, o_data);
                mismatches++;
            end else begin
                want = poc_expected.pop_front();
                if (o_data.order_count !== want.order_count) begin
                    $display("%0t: order_count expected %0d got %0d", $time,
                             want.order_count, o_data.order_count);
                    mismatches++;
                end
                if (o_data.frame_offset !== want.frame_offset) begin
                    $display("%0t: frame_offset expected %h got %h", $time,
                             want.frame_offset, o_data.frame_offset);
                    mismatches++;
                end
                if (o_data.order_msb !== want.order_msb) begin
                    $display("%0t: order_msb expected %0d got %0d", $time,
                             want.order_msb, o_data.order_msb);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, poc_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_poc_in s;
        cfg_log2_fnum   = 5'd4;
        cfg_log2_lsb    = 5'd4;
        cfg_type        = POC_TYPE_LSB;
        cfg_frames_only = 1'b0;
        cfg_cycle_len   = '0;
        cfg_off_nonref  = '0;
        cfg_off_t2b     = '0;
        table_ptr       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: type 0 with 16-entry moduli.
        s = '0;
        slice_queue.push_back(s);
        s = '1;
        slice_queue.push_back(s);
        s.is_idr = 1'b0;
        slice_queue.push_back(s);
        s = '0;
        s.is_idr = 1'b1; s.is_reference = 1'b1; s.order_lsb = 5;
        s.prev_order_lsb = 12; s.prev_order_msb = 64; s.prev_frame_offset = 100;
        slice_queue.push_back(s);
        s = '0;
        s.is_reference = 1'b1; s.order_lsb = 1; s.prev_order_lsb = 14; s.prev_order_msb = 32;
        slice_queue.push_back(s);
        s.order_lsb = 14; s.prev_order_lsb = 1;
        slice_queue.push_back(s);
        s.order_lsb = 0; s.prev_order_lsb = 8;
        slice_queue.push_back(s);
        s.order_lsb = 8; s.prev_order_lsb = 0;
        slice_queue.push_back(s);
        s = '0;
        s.field_picture = 1'b1; s.order_lsb = 3; s.delta_second = -5;
        slice_queue.push_back(s);
        s.bottom_field = 1'b1;
        slice_queue.push_back(s);
        s.field_picture = 1'b0;
        slice_queue.push_back(s);
        s = '0;
        s.frame_number = 2; s.prev_frame_number = 9; s.prev_frame_offset = 32'hFFFF_FFF0;
        s.prev_order_msb = 32'h7FFF_FFFF; s.delta_second = 32'h8000_0000; s.order_lsb = 15;
        slice_queue.push_back(s);
        push_random(60);
        drain();

        // Widest moduli, frames only, sender and receiver never idle.
        set_mode(16, 16, POC_TYPE_LSB, 1'b1);
        steady = 1'b1;
        push_random(60);
        drain();
        steady = 1'b0;

        // Type 1 with a one-entry cycle.
        set_mode(8, 4, POC_TYPE_CYCLE, 1'b0);
        load_cycle(1, 1, $urandom, $urandom);
        s = '0;
        s.frame_number = 1;
        slice_queue.push_back(s);
        s.is_reference = 1'b1;
        slice_queue.push_back(s);
        s.is_idr = 1'b1; s.field_picture = 1'b1; s.bottom_field = 1'b1; s.delta_first = 7;
        slice_queue.push_back(s);
        s = '0;
        s.is_reference = 1'b1; s.prev_frame_offset = 32'h8000_0000; s.delta_second = 3;
        slice_queue.push_back(s);
        push_random(60);
        drain();

        // Longest cycle.
        set_mode(16, 4, POC_TYPE_CYCLE, 1'b0);
        load_cycle(255, 255, 32'h8000_0001, 32'h7FFF_FFFF);
        push_random(40);
        drain();

        // Empty cycle: the absolute frame number is always zero.
        load_cycle(0, 0, $urandom, $urandom);
        push_random(30);
        drain();

        load_cycle(5, 5, 32'h7FFF_FFFF, 32'h8000_0001);
        push_random(80);
        drain();

        // Type 2 with a modulus of one.
        set_mode(0, 4, POC_TYPE_FRAME, 1'b0);
        s = '0;
        s.is_idr = 1'b1; s.frame_number = 3;
        slice_queue.push_back(s);
        s.is_idr = 1'b0;
        slice_queue.push_back(s);
        s.field_picture = 1'b1; s.bottom_field = 1'b1; s.is_reference = 1'b1;
        slice_queue.push_back(s);
        push_random(60);
        drain();

        // Undefined type: only the frame offset is derived.
        set_mode(6, 6, POC_TYPE_NONE, 1'b0);
        s = '0;
        s.frame_number = 1; s.prev_frame_number = 5; s.order_lsb = 9;
        slice_queue.push_back(s);
        s.is_idr = 1'b1;
        slice_queue.push_back(s);
        push_random(30);
        drain();

        // Shift amounts beyond the legal range, both ends.
        set_mode(31, 31, POC_TYPE_LSB, 1'b0);
        push_random(40);
        drain();
        set_mode(0, 0, POC_TYPE_LSB, 1'b0);
        push_random(40);
        drain();

        // Load pointer wraps past the end of the table.
        set_mode(10, 4, POC_TYPE_CYCLE, 1'b0);
        load_cycle(255, 257, $urandom, $urandom);
        push_random(40);
        drain();

        set_mode(12, 5, POC_TYPE_LSB, 1'b0);
        push_random(100);
        drain();

        repeat (50) @(posedge i_clk);
        $display("Checked %0d results for %0d slice headers over POC types 0 to 3,", 
                 results_checked, slices_accepted);
        $display("frame/field/IDR slices, cycle lengths 0/1/5/255 and table pointer wrap.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> h264_picture_order_count.f
src/h264_poc_pkg.sv
src/h264_poc_table.sv
src/h264_poc_div.sv
src/h264_picture_order_count.sv
dv/tb_h264_picture_order_count.sv
